// File: rtl/prm_pkg.sv
// shared types and constants for the pulse rate meter
`default_nettype none
package prm_pkg;

	localparam int DEFAULT_SAMPLE_BITS = 12;
	localparam int DEFAULT_TIME_BITS   = 32;

	localparam int THRESHOLD_BITS = 12;
	localparam int PPM_BITS       = 4;
	localparam int CFG_DATA_BITS  = 12;
	localparam int CFG_ADDR_BITS  = 1;

	localparam int RATE_BITS     = 27;
	localparam int OUT_DATA_BITS = ((RATE_BITS + 7) / 8) * 8;
	localparam int ITER_BITS     = $clog2(RATE_BITS);

	localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 12'd2380;
	localparam logic [PPM_BITS-1:0]       PPM_RESET       = 4'd5;
	localparam logic [PPM_BITS-1:0]       PPM_MIN         = 4'd2;

	// hundredths of pulses per minute for one pulse interval per millisecond
	localparam logic [22:0] CENTI_PPM_PER_INTERVAL = 23'd6000000;

	localparam logic [CFG_ADDR_BITS-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_PULSES    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WRITE
	} state_t;

endpackage
`default_nettype wire

// File: rtl/pulse_rate_meter.sv
// pulse rate meter: rising-edge pulse counter with iterative rate divider
//
// Each input transaction carries one sensor sample and its millisecond timestamp. A pulse is
// a sample above threshold after one that was not. The Nth pulse of a measurement produces one
// output transaction with the rate in hundredths of pulses per minute, (N-1)*6000000 divided
// by the milliseconds since the first pulse, truncated; a zero interval gives rate 0 with the
// zero_interval flag set. A sample that does not complete a measurement leaves the meter ready for
// the next. A completing sample holds off the next transaction through acceptance, 27 iterations
// of the shared restoring divider (one quotient bit each) and the write of the output register,
// which waits while an earlier result is still untaken; a zero interval skips the divider. The
// output register lets samples keep flowing while a result waits to be taken.
`default_nettype none
module pulse_rate_meter #(
	parameter int SAMPLE_BITS = prm_pkg::DEFAULT_SAMPLE_BITS,
	parameter int TIME_BITS   = prm_pkg::DEFAULT_TIME_BITS
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          cfg_we,
	input  wire logic [prm_pkg::CFG_ADDR_BITS-1:0]             cfg_addr,
	input  wire logic [prm_pkg::CFG_DATA_BITS-1:0]             cfg_wdata,
	input  wire logic                                          s_axis_tvalid,
	output logic                                               s_axis_tready,
	// sample, time_ms
	input  wire logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                               m_axis_tvalid,
	input  wire logic                                          m_axis_tready,
	// rate_centi_ppm
	output logic [prm_pkg::OUT_DATA_BITS-1:0]                  m_axis_tdata,
	// zero_interval
	output logic                                               m_axis_tuser
);
	import prm_pkg::*;

	localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;
	localparam int REM_BITS = TIME_BITS + 1;

	state_t state_q, state_d;

	logic [THRESHOLD_BITS-1:0] thr_q;
	logic [PPM_BITS-1:0]       ppm_q;
	logic                      was_high_q;
	logic [PPM_BITS-1:0]       count_q;
	logic [TIME_BITS-1:0]      first_q;

	logic [RATE_BITS-1:0] num_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [TIME_BITS-1:0] den_q;
	logic [RATE_BITS-1:0] quo_q;
	logic                 err_q;
	logic [ITER_BITS-1:0] iter_q;

	logic                 m_valid_q;
	logic [RATE_BITS-1:0] rate_q;
	logic                 zi_q;

	logic [SAMPLE_BITS-1:0] sample;
	logic [TIME_BITS-1:0]   now;
	logic                   in_fire;
	logic                   high;
	logic                   rise;
	logic [PPM_BITS-1:0]    n_eff;
	logic [PPM_BITS-1:0]    count_inc;
	logic                   complete;
	logic [TIME_BITS-1:0]   elapsed;
	logic                   elapsed_zero;
	logic [RATE_BITS-1:0]   numer;
	logic [REM_BITS-1:0]    trial;
	logic [REM_BITS:0]      diff;
	logic                   ge;
	logic                   load_out;

	assign sample  = s_axis_tdata[SAMPLE_BITS-1:0];
	assign now     = s_axis_tdata[SAMPLE_BITS +: TIME_BITS];
	assign in_fire = s_axis_tvalid && s_axis_tready;

	assign high         = CMP_BITS'(sample) > CMP_BITS'(thr_q);
	assign rise         = high && !was_high_q;
	assign n_eff        = (ppm_q < PPM_MIN) ? PPM_MIN : ppm_q;
	assign count_inc    = count_q + 1'b1;
	assign complete     = rise && (count_inc >= n_eff);
	assign elapsed      = now - first_q;
	assign elapsed_zero = (elapsed == '0);
	assign numer        = RATE_BITS'((n_eff - 1'b1) * CENTI_PPM_PER_INTERVAL);

	assign trial = {rem_q[REM_BITS-2:0], num_q[RATE_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = !diff[REM_BITS];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && complete) begin
					state_d = elapsed_zero ? ST_WRITE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (iter_q == '0) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		load_out      = (state_q == ST_WRITE) && (!m_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			ppm_q <= PPM_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_THRESHOLD: thr_q <= cfg_wdata[THRESHOLD_BITS-1:0];
				REG_PULSES:    ppm_q <= cfg_wdata[PPM_BITS-1:0];
				default:       ;
			endcase
		end
	end

	// pulse detection and measurement bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_high_q <= 1'b0;
			count_q    <= '0;
			first_q    <= '0;
		end else if (in_fire) begin
			was_high_q <= high;
			if (rise) begin
				if (complete) begin
					count_q <= '0;
					first_q <= '0;
				end else begin
					count_q <= count_inc;
					if (count_inc == 4'd1) begin
						first_q <= now;
					end
				end
			end
		end
	end

	// shared restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (state_q == ST_IDLE) begin
			iter_q <= ITER_BITS'(RATE_BITS - 1);
		end else if (state_q == ST_DIV) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= elapsed;
			quo_q <= '0;
			err_q <= elapsed_zero;
		end else if (state_q == ST_DIV) begin
			num_q <= {num_q[RATE_BITS-2:0], 1'b0};
			rem_q <= ge ? diff[REM_BITS-1:0] : trial;
			quo_q <= {quo_q[RATE_BITS-2:0], ge};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rate_q <= quo_q;
			zi_q   <= err_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DATA_BITS'(rate_q);
	assign m_axis_tuser  = zi_q;

endmodule
`default_nettype wire
